// ===== hw/rtl/first_line_language_sniffer_top_defines.svh =====
// Assertion macros for the first-line language sniffer.
// Used by first_line_language_sniffer_top; the bodies assume clk_i and rst_ni exist.
`ifndef FIRST_LINE_LANGUAGE_SNIFFER_TOP_DEFINES_SVH
`define FIRST_LINE_LANGUAGE_SNIFFER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FLS_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FLS_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/fls_pkg.sv =====
// Shared types, byte constants and match patterns of the first-line language sniffer.
// No dependencies; used by fls_line_scan and first_line_language_sniffer_top.
package fls_pkg;

  // Number of first-line bytes that are examined.
  localparam int LINE_WINDOW = 40;
  localparam int LEN_W       = $clog2(LINE_WINDOW + 1);

  // Interpreter names searched anywhere in a shebang line; byte 0 is the last character.
  localparam int TAIL_N = 6;
  localparam int NUM_IN = 6;
  typedef logic [TAIL_N-1:0][7:0] tail_pat_t;

  localparam int IN_SH     = 0;
  localparam int IN_PYTHON = 1;
  localparam int IN_PERL   = 2;
  localparam int IN_PHP    = 3;
  localparam int IN_RUBY   = 4;
  localparam int IN_NODE   = 5;

  localparam tail_pat_t IN_PAT [NUM_IN] = '{
    {32'h0, "sh"},
    "python",
    {16'h0, "perl"},
    {24'h0, "php"},
    {16'h0, "ruby"},
    {16'h0, "node"}
  };
  localparam int IN_LEN [NUM_IN] = '{2, 6, 4, 3, 4, 4};

  // Line prefixes; byte PFX_N-1 is the first character, unused bytes are zero.
  localparam int PFX_N   = 14;
  localparam int NUM_PFX = 6;
  typedef logic [PFX_N-1:0][7:0] pfx_pat_t;

  localparam int PFX_SHEBANG = 0;
  localparam int PFX_XML     = 1;
  localparam int PFX_PHPTAG  = 2;
  localparam int PFX_HTML    = 3;
  localparam int PFX_DOCTYPE = 4;
  localparam int PFX_PI      = 5;

  localparam pfx_pat_t PFX_PAT [NUM_PFX] = '{
    {"#!", 96'h0},
    {"<?xml", 72'h0},
    {"<?php", 72'h0},
    {"<html", 72'h0},
    "<!DOCTYPE html",
    {"<?", 96'h0}
  };
  localparam int PFX_LEN [NUM_PFX] = '{2, 5, 5, 5, 14, 2};

  // Special bytes.
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] BOM_0  = 8'hEF;
  localparam logic [7:0] BOM_1  = 8'hBB;
  localparam logic [7:0] BOM_2  = 8'hBF;

  // Scanning phase of the current text.
  typedef enum logic [3:0] {
    PH_HEAD = 4'b0001,
    PH_SKIP = 4'b0010,
    PH_LINE = 4'b0100,
    PH_DONE = 4'b1000
  } phase_e;

  // Language codes of a result.
  typedef enum logic [3:0] {
    LANG_NONE   = 4'd0,
    LANG_BASH   = 4'd1,
    LANG_PYTHON = 4'd2,
    LANG_PERL   = 4'd3,
    LANG_PHP    = 4'd4,
    LANG_RUBY   = 4'd5,
    LANG_JS     = 4'd6,
    LANG_XML    = 4'd7,
    LANG_HTML   = 4'd8
  } lang_e;

  // Running match state of the first line.
  typedef struct packed {
    phase_e                    phase;
    logic [LEN_W-1:0]          len;
    logic [TAIL_N-2:0][7:0]    tail;
    logic [NUM_IN-1:0]         found;
    logic [NUM_PFX-1:0]        pfx_ok;
  } line_t;

  localparam line_t LINE_INIT = '{
    phase:  PH_HEAD,
    len:    '0,
    tail:   '0,
    found:  '0,
    pfx_ok: '1
  };

  // Status of the scanner, seen by the top level.
  typedef struct packed {
    phase_e           phase;
    logic [LEN_W-1:0] len;
    logic [2:0]       count;
  } scan_status_t;

endpackage

// ===== hw/rtl/first_line_language_sniffer_top.sv =====
// A byte is captured in the input register and scanned from there; a closing byte's result goes to the result register.
// Throughput: one byte per cycle, except while a closing byte is held behind a stalled result.
// The input register is released while a result waits, unless it holds a closing byte.
// Reset (rst_ni low, asynchronous) empties both registers and clears the scan state.
// Uses fls_pkg, fls_line_scan and first_line_language_sniffer_top_defines.svh.
`include "first_line_language_sniffer_top_defines.svh"

module first_line_language_sniffer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] language_o
);

  logic                  s1_vld_q;
  logic [7:0]            s1_byte_q;
  logic                  s1_last_q;
  logic                  out_vld_q;
  fls_pkg::lang_e        lang_q;
  fls_pkg::lang_e        scan_lang;
  fls_pkg::scan_status_t scan_status;
  logic                  out_free;
  logic                  s1_go;
  logic                  in_acc;

  // Handshake: the held byte moves on unless it closes a text and the result slot is full and stalled.
  assign out_free   = !out_vld_q || !out_stall_i;
  assign s1_go      = s1_vld_q && (!s1_last_q || out_free);
  assign in_stall_o = s1_vld_q && !s1_go;
  assign in_acc     = in_valid_i && !in_stall_o;

  fls_line_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_go),
    .byte_i   (s1_byte_q),
    .last_i   (s1_last_q),
    .lang_o   (scan_lang),
    .status_o (scan_status)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_acc) begin
      s1_vld_q <= 1'b1;
    end else if (s1_go) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_go && s1_last_q) begin
      out_vld_q <= 1'b1;
    end else if (out_free) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_last_q) begin
      lang_q <= scan_lang;
    end
  end

  assign out_valid_o = out_vld_q;
  assign language_o  = lang_q;

  // Checks.
  `FLS_ASSERT_NXT(a_close_gives_result, s1_go && s1_last_q, out_valid_o, "closing byte gave no result")
  `FLS_ASSERT_NXT(a_close_resets_count, s1_go && s1_last_q, scan_status.count == 3'd0, "byte count not cleared after closing byte")
  `FLS_ASSERT_IMP(a_len_in_window, 1'b1, scan_status.len <= fls_pkg::LEN_W'(fls_pkg::LINE_WINDOW), "line length beyond window")
  `FLS_ASSERT_IMP(a_stall_only_when_held, in_stall_o, s1_vld_q && s1_last_q && out_vld_q, "input stalled without a waiting closing byte")

endmodule

// ===== hw/rtl/fls_line_scan.sv =====
// Per-text scanner: head bytes, white-space skip, first-line matching and classification.
// Depends on fls_pkg.
module fls_line_scan (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  input  logic                  last_i,
  output fls_pkg::lang_e        lang_o,
  output fls_pkg::scan_status_t status_o
);

  fls_pkg::line_t line_q, line_d, line_nxt;
  logic [2:0]     count_q, count_d, count_nxt;
  logic [7:0]     head_q [2];
  logic           is_bom;

  // True when the stored tail plus the new byte end with the pattern.
  function automatic logic tail_hit(fls_pkg::tail_pat_t win, fls_pkg::tail_pat_t pat, int n);
    logic hit;
    hit = 1'b1;
    for (int i = 0; i < fls_pkg::TAIL_N; i++) begin
      if (i < n && win[i] != pat[i]) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

  // One byte through the skip and store logic.
  function automatic fls_pkg::line_t feed(fls_pkg::line_t s, logic [7:0] b);
    fls_pkg::line_t      r;
    logic                nl;
    logic                blank;
    fls_pkg::tail_pat_t  win;
    logic [3:0]          pidx;
    r     = s;
    nl    = (b == fls_pkg::CH_CR) || (b == fls_pkg::CH_LF);
    blank = nl || (b == fls_pkg::CH_SP) || (b == fls_pkg::CH_TAB);
    win   = {s.tail, b};
    pidx  = '0;
    if (r.phase == fls_pkg::PH_SKIP && !blank) begin
      r.phase = fls_pkg::PH_LINE;
    end
    if (r.phase == fls_pkg::PH_LINE) begin
      if (nl || r.len >= fls_pkg::LEN_W'(fls_pkg::LINE_WINDOW)) begin
        r.phase = fls_pkg::PH_DONE;
      end else begin
        // Interpreter names may end at any stored position.
        for (int k = 0; k < fls_pkg::NUM_IN; k++) begin
          if (s.len >= fls_pkg::LEN_W'(fls_pkg::IN_LEN[k] - 1) &&
              tail_hit(win, fls_pkg::IN_PAT[k], fls_pkg::IN_LEN[k])) begin
            r.found[k] = 1'b1;
          end
        end
        // Prefixes are checked one position at a time.
        for (int k = 0; k < fls_pkg::NUM_PFX; k++) begin
          if (s.len < fls_pkg::LEN_W'(fls_pkg::PFX_LEN[k])) begin
            pidx = 4'(fls_pkg::PFX_N - 1) - s.len[3:0];
            if (b != fls_pkg::PFX_PAT[k][pidx]) begin
              r.pfx_ok[k] = 1'b0;
            end
          end
        end
        r.tail = win[fls_pkg::TAIL_N-2:0];
        r.len  = s.len + 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic pfx_hit(fls_pkg::line_t s, int k);
    return s.pfx_ok[k] && (s.len >= fls_pkg::LEN_W'(fls_pkg::PFX_LEN[k]));
  endfunction

  // Language decision from the line state after the closing byte.
  function automatic fls_pkg::lang_e classify(fls_pkg::line_t s, logic long_text);
    fls_pkg::lang_e l;
    l = fls_pkg::LANG_NONE;
    if (long_text) begin
      if (pfx_hit(s, fls_pkg::PFX_SHEBANG)) begin
        if (s.found[fls_pkg::IN_SH])          l = fls_pkg::LANG_BASH;
        else if (s.found[fls_pkg::IN_PYTHON]) l = fls_pkg::LANG_PYTHON;
        else if (s.found[fls_pkg::IN_PERL])   l = fls_pkg::LANG_PERL;
        else if (s.found[fls_pkg::IN_PHP])    l = fls_pkg::LANG_PHP;
        else if (s.found[fls_pkg::IN_RUBY])   l = fls_pkg::LANG_RUBY;
        else if (s.found[fls_pkg::IN_NODE])   l = fls_pkg::LANG_JS;
      end else begin
        if (pfx_hit(s, fls_pkg::PFX_XML))          l = fls_pkg::LANG_XML;
        else if (pfx_hit(s, fls_pkg::PFX_PHPTAG))  l = fls_pkg::LANG_PHP;
        else if (pfx_hit(s, fls_pkg::PFX_HTML))    l = fls_pkg::LANG_HTML;
        else if (pfx_hit(s, fls_pkg::PFX_DOCTYPE)) l = fls_pkg::LANG_HTML;
        else if (pfx_hit(s, fls_pkg::PFX_PI))      l = fls_pkg::LANG_PHP;
      end
    end
    return l;
  endfunction

  assign is_bom = (head_q[0] == fls_pkg::BOM_0) && (head_q[1] == fls_pkg::BOM_1) &&
                  (byte_i == fls_pkg::BOM_2);

  // Next state for the byte under way; the third byte releases the held head bytes.
  always_comb begin
    line_nxt = line_q;
    if (count_q < 3'd3) begin
      count_nxt = count_q + 3'd1;
      if (count_q == 3'd2) begin
        line_nxt.phase = fls_pkg::PH_SKIP;
        if (!is_bom) begin
          line_nxt = feed(feed(feed(line_nxt, head_q[0]), head_q[1]), byte_i);
        end
      end
    end else begin
      count_nxt = 3'd4;
      line_nxt  = feed(line_q, byte_i);
    end
  end

  assign lang_o = classify(line_nxt, count_nxt == 3'd4);

  // The closing byte returns the scanner to its reset state.
  always_comb begin
    line_d  = line_q;
    count_d = count_q;
    if (step_i) begin
      if (last_i) begin
        line_d  = fls_pkg::LINE_INIT;
        count_d = '0;
      end else begin
        line_d  = line_nxt;
        count_d = count_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q  <= fls_pkg::LINE_INIT;
      count_q <= '0;
    end else begin
      line_q  <= line_d;
      count_q <= count_d;
    end
  end

  // The first two bytes wait here until the third one arrives.
  always_ff @(posedge clk_i) begin
    if (step_i && count_q < 3'd2) begin
      head_q[count_q[0]] <= byte_i;
    end
  end

  assign status_o = '{phase: line_q.phase, len: line_q.len, count: count_q};

endmodule
